// ===== sv/sslex_pkg.sv =====
package sslex_pkg;

   localparam int POSITION_WIDTH_DEFAULT = 16;
   localparam int POS_FIELD_W = 16;

   localparam int MAX_RECS = 5;
   localparam int REC_CNT_W = $clog2(MAX_RECS + 1);
   localparam int QUEUE_DEPTH = 2;

   localparam int KW_COUNT = 18;
   localparam int KW_BUF_W = 56;
   localparam int KW_MAX_LEN = 7;
   localparam int ID_LEN_W = 4;

   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_TOKEN = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [4:0] TY_NONE   = 5'd0;
   localparam logic [4:0] TY_IDENT  = 5'd18;
   localparam logic [4:0] TY_NUMBER = 5'd19;
   localparam logic [4:0] TY_STRING = 5'd20;
   localparam logic [4:0] TY_STAR   = 5'd21;
   localparam logic [4:0] TY_COMMA  = 5'd22;
   localparam logic [4:0] TY_LPAREN = 5'd23;
   localparam logic [4:0] TY_RPAREN = 5'd24;
   localparam logic [4:0] TY_SEMI   = 5'd25;
   localparam logic [4:0] TY_EQUAL  = 5'd26;
   localparam logic [4:0] TY_DOT    = 5'd27;
   localparam logic [4:0] TY_EOF    = 5'd28;

   localparam logic ERR_UNEXPECTED   = 1'b0;
   localparam logic ERR_UNTERMINATED = 1'b1;

   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_LF         = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_QUOTE      = 8'h27;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_COMMA      = 8'h2C;
   localparam logic [7:0] CH_DASH       = 8'h2D;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_SEMI       = 8'h3B;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   // Keywords packed most significant character first, in token type order
   localparam logic [KW_BUF_W-1:0] KW_TEXT [KW_COUNT] = '{
      56'h00_494E53455254,  // INSERT
      56'h00_0000494E544F,  // INTO
      56'h00_56414C554553,  // VALUES
      56'h00_53454C454354,  // SELECT
      56'h00_000000544F50,  // TOP
      56'h00_000046524F4D,  // FROM
      56'h00_005748455245,  // WHERE
      56'h00_004F52444552,  // ORDER
      56'h00_000000004259,  // BY
      56'h00_000000415343,  // ASC
      56'h00_000044455343,  // DESC
      56'h00_004C494D4954,  // LIMIT
      56'h5052494D415259,   // PRIMARY
      56'h00_0000004B4559,  // KEY
      56'h00_435245415445,  // CREATE
      56'h00_005441424C45,  // TABLE
      56'h00_000044524F50,  // DROP
      56'h00_44454C455445   // DELETE
   };

   localparam logic [ID_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      4'd6, 4'd4, 4'd6, 4'd6, 4'd3, 4'd4, 4'd5, 4'd5, 4'd2,
      4'd3, 4'd4, 4'd5, 4'd7, 4'd3, 4'd6, 4'd5, 4'd4, 4'd6
   };

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [1:0]             record_kind;
      logic [4:0]             token_type;
      logic [7:0]             text_byte;
      logic [POS_FIELD_W-1:0] at_line;
      logic [POS_FIELD_W-1:0] at_column;
      logic                   error_code;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic [REC_CNT_W-1:0]       count;
      rsp_type [MAX_RECS-1:0]     recs;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } queue_status_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] ttype;
   } punct_match_type;

   function automatic logic is_alpha(input logic [7:0] ch);
      return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return ch >= 8'h30 && ch <= 8'h39;
   endfunction

   function automatic logic is_blank(input logic [7:0] ch);
      return ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] ch);
      return (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;
   endfunction

   function automatic punct_match_type punct_match(input logic [7:0] ch);
      punct_match_type m;
      m.hit = 1'b1;
      unique case (ch)
         CH_STAR:   m.ttype = TY_STAR;
         CH_COMMA:  m.ttype = TY_COMMA;
         CH_LPAREN: m.ttype = TY_LPAREN;
         CH_RPAREN: m.ttype = TY_RPAREN;
         CH_SEMI:   m.ttype = TY_SEMI;
         CH_EQUAL:  m.ttype = TY_EQUAL;
         CH_DOT:    m.ttype = TY_DOT;
         default: begin
            m.hit   = 1'b0;
            m.ttype = TY_NONE;
         end
      endcase
      return m;
   endfunction

   function automatic logic [4:0] kw_lookup(input logic [KW_BUF_W-1:0] kbuf,
                                            input logic [ID_LEN_W-1:0] klen);
      logic [4:0] r;
      r = TY_IDENT;
      if (klen <= ID_LEN_W'(KW_MAX_LEN)) begin
         for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (klen == KW_LEN[k] && kbuf == KW_TEXT[k]) begin
               r = 5'(k);
            end
         end
      end
      return r;
   endfunction

   function automatic rsp_type mk_rec(input logic [1:0] kind, input logic [4:0] ttype,
                                      input logic [7:0] tbyte,
                                      input logic [POS_FIELD_W-1:0] ln,
                                      input logic [POS_FIELD_W-1:0] col,
                                      input logic err);
      rsp_type r;
      r.record_kind  = kind;
      r.token_type   = ttype;
      r.text_byte    = tbyte;
      r.at_line      = ln;
      r.at_column    = col;
      r.error_code   = err;
      r.last         = 1'b0;
      return r;
   endfunction

endpackage

// ===== sv/sslex_front.sv =====
module sslex_front #(
   parameter int POSITION_WIDTH = sslex_pkg::POSITION_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  sslex_pkg::req_type           req_data,
   output logic                         req_stall,
   input  sslex_pkg::queue_status_type  q_status,
   output logic                         push,
   output sslex_pkg::bundle_type        push_data
);
   import sslex_pkg::*;

   localparam logic [3:0] M_IDLE     = 4'd0;
   localparam logic [3:0] M_IDENT    = 4'd1;
   localparam logic [3:0] M_NUMBER   = 4'd2;
   localparam logic [3:0] M_NUMDOT   = 4'd3;
   localparam logic [3:0] M_NUMFRAC  = 4'd4;
   localparam logic [3:0] M_STRING   = 4'd5;
   localparam logic [3:0] M_STRQUOTE = 4'd6;
   localparam logic [3:0] M_DASH     = 4'd7;
   localparam logic [3:0] M_COMMENT  = 4'd8;
   localparam logic [3:0] M_DISCARD  = 4'd9;

   localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);
   localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};
   localparam logic [ID_LEN_W-1:0]       LEN_MAX = {ID_LEN_W{1'b1}};

   logic [3:0]                mode_ff, mode_in;
   logic [POSITION_WIDTH-1:0] line_ff, line_in;
   logic [POSITION_WIDTH-1:0] col_ff, col_in;
   logic [POSITION_WIDTH-1:0] tok_line_ff, tok_line_in;
   logic [POSITION_WIDTH-1:0] tok_col_ff, tok_col_in;
   logic [POSITION_WIDTH-1:0] held_col_ff, held_col_in;
   logic [KW_BUF_W-1:0]       kw_ff, kw_in;
   logic [ID_LEN_W-1:0]       len_ff, len_in;

   logic                      accept;
   logic [7:0]                c;
   logic                      at_end;
   logic [POS_FIELD_W-1:0]    cur_line16, cur_col16, tok_line16, tok_col16, held_col16;
   logic [POSITION_WIDTH-1:0] adv_line, adv_col;
   logic [4:0]                kw_ttype;
   punct_match_type           pm;
   bundle_type                bun;
   logic [REC_CNT_W-1:0]      rec_cnt;
   logic                      do_idle, do_adv, do_start;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign c         = req_data.char_byte;
   assign at_end    = req_data.end_of_input || (c == CH_NUL);

   assign cur_line16 = POS_FIELD_W'(line_ff);
   assign cur_col16  = POS_FIELD_W'(col_ff);
   assign tok_line16 = POS_FIELD_W'(tok_line_ff);
   assign tok_col16  = POS_FIELD_W'(tok_col_ff);
   assign held_col16 = POS_FIELD_W'(held_col_ff);

   assign kw_ttype = kw_lookup(kw_ff, len_ff);
   assign pm       = punct_match(c);

   // Position after consuming the current byte, saturating
   always_comb begin
      if (c == CH_LF) begin
         adv_line = (line_ff != POS_MAX) ? line_ff + 1'b1 : line_ff;
         adv_col  = POS_ONE;
      end else begin
         adv_line = line_ff;
         adv_col  = (col_ff != POS_MAX) ? col_ff + 1'b1 : col_ff;
      end
   end

   always_comb begin
      bun         = '0;
      rec_cnt     = '0;
      mode_in     = mode_ff;
      kw_in       = kw_ff;
      len_in      = len_ff;
      held_col_in = held_col_ff;
      do_idle     = 1'b0;
      do_adv      = 1'b0;
      do_start    = 1'b0;

      if (at_end) begin
         // Close the open token, then EOF unless an error takes its place or an earlier error left the lexer discarding
         unique case (mode_ff)
            M_IDENT: begin
               bun.recs[rec_cnt] = mk_rec(KIND_TOKEN, kw_ttype, CH_NUL, tok_line16,
                                          tok_col16, ERR_UNEXPECTED);
               rec_cnt = rec_cnt + 1'b1;
            end
            M_NUMBER, M_NUMFRAC, M_STRQUOTE: begin
               bun.recs[rec_cnt] = mk_rec(KIND_TOKEN,
                                          (mode_ff == M_STRQUOTE) ? TY_STRING : TY_NUMBER,
                                          CH_NUL, tok_line16, tok_col16, ERR_UNEXPECTED);
               rec_cnt = rec_cnt + 1'b1;
            end
            M_NUMDOT: begin
               bun.recs[rec_cnt] = mk_rec(KIND_TOKEN, TY_NUMBER, CH_NUL, tok_line16,
                                          tok_col16, ERR_UNEXPECTED);
               rec_cnt = rec_cnt + 1'b1;
               bun.recs[rec_cnt] = mk_rec(KIND_TEXT, TY_NONE, CH_DOT, cur_line16,
                                          held_col16, ERR_UNEXPECTED);
               rec_cnt = rec_cnt + 1'b1;
               bun.recs[rec_cnt] = mk_rec(KIND_TOKEN, TY_DOT, CH_NUL, cur_line16,
                                          held_col16, ERR_UNEXPECTED);
               rec_cnt = rec_cnt + 1'b1;
            end
            M_STRING, M_DASH: begin
               bun.recs[rec_cnt] = mk_rec(KIND_ERROR, TY_NONE, CH_NUL, tok_line16, tok_col16,
                                          (mode_ff == M_STRING) ? ERR_UNTERMINATED
                                                                : ERR_UNEXPECTED);
               rec_cnt = rec_cnt + 1'b1;
            end
            default: ;
         endcase
         if (mode_ff != M_STRING && mode_ff != M_DASH && mode_ff != M_DISCARD) begin
            bun.recs[rec_cnt] = mk_rec(KIND_TOKEN, TY_EOF, CH_NUL, cur_line16, cur_col16,
                                       ERR_UNEXPECTED);
            rec_cnt = rec_cnt + 1'b1;
         end
      end else begin
         unique case (mode_ff)
            M_IDENT: begin
               if (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE) begin
                  bun.recs[rec_cnt] = mk_rec(KIND_TEXT, TY_NONE, c, tok_line16, tok_col16,
                                             ERR_UNEXPECTED);
                  rec_cnt = rec_cnt + 1'b1;
                  if (len_ff < ID_LEN_W'(KW_MAX_LEN)) begin
                     kw_in = {kw_ff[KW_BUF_W-9:0], to_upper(c)};
                  end
                  if (len_ff != LEN_MAX) begin
                     len_in = len_ff + 1'b1;
                  end
                  do_adv = 1'b1;
               end else begin
                  bun.recs[rec_cnt] = mk_rec(KIND_TOKEN, kw_ttype, CH_NUL, tok_line16,
                                             tok_col16, ERR_UNEXPECTED);
                  rec_cnt = rec_cnt + 1'b1;
                  do_idle = 1'b1;
               end
            end
            M_NUMBER, M_NUMFRAC: begin
               if (is_digit(c)) begin
                  bun.recs[rec_cnt] = mk_rec(KIND_TEXT, TY_NONE, c, tok_line16, tok_col16,
                                             ERR_UNEXPECTED);
                  rec_cnt = rec_cnt + 1'b1;
                  do_adv = 1'b1;
               end else if (c == CH_DOT && mode_ff == M_NUMBER) begin
                  held_col_in = col_ff;
                  mode_in     = M_NUMDOT;
                  do_adv      = 1'b1;
               end else begin
                  bun.recs[rec_cnt] = mk_rec(KIND_TOKEN, TY_NUMBER, CH_NUL, tok_line16,
                                             tok_col16, ERR_UNEXPECTED);
                  rec_cnt = rec_cnt + 1'b1;
                  do_idle = 1'b1;
               end
            end
            M_NUMDOT: begin
               if (is_digit(c)) begin
                  bun.recs[rec_cnt] = mk_rec(KIND_TEXT, TY_NONE, CH_DOT, tok_line16,
                                             tok_col16, ERR_UNEXPECTED);
                  rec_cnt = rec_cnt + 1'b1;
                  bun.recs[rec_cnt] = mk_rec(KIND_TEXT, TY_NONE, c, tok_line16, tok_col16,
                                             ERR_UNEXPECTED);
                  rec_cnt = rec_cnt + 1'b1;
                  mode_in = M_NUMFRAC;
                  do_adv  = 1'b1;
               end else begin
                  // The held dot was not a decimal point: close the number, then a DOT
                  bun.recs[rec_cnt] = mk_rec(KIND_TOKEN, TY_NUMBER, CH_NUL, tok_line16,
                                             tok_col16, ERR_UNEXPECTED);
                  rec_cnt = rec_cnt + 1'b1;
                  bun.recs[rec_cnt] = mk_rec(KIND_TEXT, TY_NONE, CH_DOT, cur_line16,
                                             held_col16, ERR_UNEXPECTED);
                  rec_cnt = rec_cnt + 1'b1;
                  bun.recs[rec_cnt] = mk_rec(KIND_TOKEN, TY_DOT, CH_NUL, cur_line16,
                                             held_col16, ERR_UNEXPECTED);
                  rec_cnt = rec_cnt + 1'b1;
                  do_idle = 1'b1;
               end
            end
            M_STRING: begin
               if (c == CH_QUOTE) begin
                  mode_in = M_STRQUOTE;
               end else begin
                  bun.recs[rec_cnt] = mk_rec(KIND_TEXT, TY_NONE, c, tok_line16, tok_col16,
                                             ERR_UNEXPECTED);
                  rec_cnt = rec_cnt + 1'b1;
               end
               do_adv = 1'b1;
            end
            M_STRQUOTE: begin
               if (c == CH_QUOTE) begin
                  bun.recs[rec_cnt] = mk_rec(KIND_TEXT, TY_NONE, CH_QUOTE, tok_line16,
                                             tok_col16, ERR_UNEXPECTED);
                  rec_cnt = rec_cnt + 1'b1;
                  mode_in = M_STRING;
                  do_adv  = 1'b1;
               end else begin
                  bun.recs[rec_cnt] = mk_rec(KIND_TOKEN, TY_STRING, CH_NUL, tok_line16,
                                             tok_col16, ERR_UNEXPECTED);
                  rec_cnt = rec_cnt + 1'b1;
                  do_idle = 1'b1;
               end
            end
            M_DASH: begin
               if (c == CH_DASH) begin
                  mode_in = M_COMMENT;
                  do_adv  = 1'b1;
               end else begin
                  bun.recs[rec_cnt] = mk_rec(KIND_ERROR, TY_NONE, CH_NUL, tok_line16,
                                             tok_col16, ERR_UNEXPECTED);
                  rec_cnt = rec_cnt + 1'b1;
                  mode_in = M_DISCARD;
               end
            end
            M_COMMENT: begin
               if (c == CH_LF) begin
                  do_idle = 1'b1;
               end else begin
                  do_adv = 1'b1;
               end
            end
            M_DISCARD: ;
            default: do_idle = 1'b1;
         endcase

         // Start of a fresh token from the current byte
         if (do_idle) begin
            mode_in = M_IDLE;
            if (is_blank(c)) begin
               do_adv = 1'b1;
            end else if (c == CH_DASH) begin
               do_start = 1'b1;
               mode_in  = M_DASH;
               do_adv   = 1'b1;
            end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
               do_start = 1'b1;
               mode_in  = M_IDENT;
               kw_in    = KW_BUF_W'(to_upper(c));
               len_in   = ID_LEN_W'(1);
               bun.recs[rec_cnt] = mk_rec(KIND_TEXT, TY_NONE, c, cur_line16, cur_col16,
                                          ERR_UNEXPECTED);
               rec_cnt = rec_cnt + 1'b1;
               do_adv  = 1'b1;
            end else if (is_digit(c)) begin
               do_start = 1'b1;
               mode_in  = M_NUMBER;
               bun.recs[rec_cnt] = mk_rec(KIND_TEXT, TY_NONE, c, cur_line16, cur_col16,
                                          ERR_UNEXPECTED);
               rec_cnt = rec_cnt + 1'b1;
               do_adv  = 1'b1;
            end else if (c == CH_QUOTE) begin
               do_start = 1'b1;
               mode_in  = M_STRING;
               do_adv   = 1'b1;
            end else if (pm.hit) begin
               bun.recs[rec_cnt] = mk_rec(KIND_TEXT, TY_NONE, c, cur_line16, cur_col16,
                                          ERR_UNEXPECTED);
               rec_cnt = rec_cnt + 1'b1;
               bun.recs[rec_cnt] = mk_rec(KIND_TOKEN, pm.ttype, CH_NUL, cur_line16,
                                          cur_col16, ERR_UNEXPECTED);
               rec_cnt = rec_cnt + 1'b1;
               do_adv  = 1'b1;
            end else begin
               bun.recs[rec_cnt] = mk_rec(KIND_ERROR, TY_NONE, CH_NUL, cur_line16, cur_col16,
                                          ERR_UNEXPECTED);
               rec_cnt = rec_cnt + 1'b1;
               mode_in = M_DISCARD;
            end
         end
      end

      bun.count = rec_cnt;
   end

   always_comb begin
      tok_line_in = do_start ? line_ff : tok_line_ff;
      tok_col_in  = do_start ? col_ff : tok_col_ff;
      line_in     = do_adv ? adv_line : line_ff;
      col_in      = do_adv ? adv_col : col_ff;
   end

   assign push      = accept && (rec_cnt != '0);
   assign push_data = bun;

   always_ff @(posedge clock) begin
      if (reset || (accept && at_end)) begin
         mode_ff     <= M_IDLE;
         line_ff     <= POS_ONE;
         col_ff      <= POS_ONE;
         tok_line_ff <= POS_ONE;
         tok_col_ff  <= POS_ONE;
         held_col_ff <= POS_ONE;
         kw_ff       <= '0;
         len_ff      <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
         tok_line_ff <= tok_line_in;
         tok_col_ff  <= tok_col_in;
         held_col_ff <= held_col_in;
         kw_ff       <= kw_in;
         len_ff      <= len_in;
      end
   end

endmodule

// ===== sv/sslex_queue.sv =====
module sslex_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  sslex_pkg::bundle_type        push_data,
   input  logic                         pop,
   output sslex_pkg::queue_status_type  status,
   output sslex_pkg::bundle_type        head
);
   import sslex_pkg::*;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

   bundle_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   assign status.full       = (fill_ff == FILL_FULL);
   assign status.head_valid = (fill_ff != '0);
   assign head              = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/sslex_back.sv =====
module sslex_back (
   input  logic                         clock,
   input  logic                         reset,
   input  sslex_pkg::queue_status_type  q_status,
   input  sslex_pkg::bundle_type        head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sslex_pkg::rsp_type           rsp_data
);
   import sslex_pkg::*;

   logic [REC_CNT_W-1:0] idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic                 load;
   logic                 final_rec;

   // Refill the output register from the queue head whenever it is empty or being taken
   assign load      = q_status.head_valid && (!rsp_valid_ff || !rsp_stall);
   assign final_rec = (idx_ff == head.count - 1'b1);
   assign pop       = load && final_rec;

   always_comb begin
      idx_in       = idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_data_in      = head.recs[idx_ff];
         rsp_data_in.last = final_rec;
         rsp_valid_in     = 1'b1;
         idx_in           = final_rec ? '0 : idx_ff + 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/sql_subset_lexer_core.sv =====
// The first result of a byte passes the queue entry, then the output register, to rsp_data.
// Throughput: one byte per cycle while each byte yields at most one result and rsp_stall
// stays low; a byte with several results holds the output side until all have left, and
// the two-entry queue after the lexing stage absorbs such bursts before req_stall rises.
// Reset (synchronous): lexer idle at line 1 column 1, queue empty, no result valid.
module sql_subset_lexer_core #(
   parameter int POSITION_WIDTH = sslex_pkg::POSITION_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sslex_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sslex_pkg::rsp_type  rsp_data
);
   import sslex_pkg::*;

   queue_status_type q_status;
   logic             push;
   bundle_type       push_data;
   logic             pop;
   bundle_type       head;

   sslex_front #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   sslex_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .status    (q_status),
      .head      (head)
   );

   sslex_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   import sslex_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 330;
   localparam logic [15:0] POS_TOP = 16'hFFFF;
   localparam logic NO_ERR = 1'b0;
   localparam rsp_type NO_REC = '0;

   typedef enum logic [3:0] {
      LS_IDLE, LS_WORD, LS_INT, LS_INT_DOT, LS_FRAC,
      LS_STR, LS_STR_QUOTE, LS_DASH, LS_COMMENT, LS_SKIP
   } lex_state_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
      logic       typed;
      rsp_type    want;
   } plan_row_type;

   // Rows with typed set carry the single record the byte must produce
   localparam plan_row_type PLAN [26] = '{
      '{CH_NUL,   1'b0, 1'b1, '{KIND_TOKEN, TY_EOF, 8'h00, 16'd1, 16'd1, NO_ERR, 1'b1}},
      '{8'h41,    1'b1, 1'b1, '{KIND_TOKEN, TY_EOF, 8'h00, 16'd1, 16'd1, NO_ERR, 1'b1}},
      '{8'hFF,    1'b0, 1'b1,
        '{KIND_ERROR, TY_NONE, 8'h00, 16'd1, 16'd1, ERR_UNEXPECTED, 1'b1}},
      '{8'h78,    1'b0, 1'b0, NO_REC},
      '{CH_SPACE, 1'b1, 1'b0, NO_REC},
      '{CH_QUOTE, 1'b0, 1'b0, NO_REC},
      '{8'h61,    1'b0, 1'b1, '{KIND_TEXT, TY_NONE, 8'h61, 16'd1, 16'd1, NO_ERR, 1'b1}},
      '{8'h62,    1'b1, 1'b1,
        '{KIND_ERROR, TY_NONE, 8'h00, 16'd1, 16'd1, ERR_UNTERMINATED, 1'b1}},
      '{CH_DASH,  1'b0, 1'b0, NO_REC},
      '{8'h37,    1'b0, 1'b1,
        '{KIND_ERROR, TY_NONE, 8'h00, 16'd1, 16'd1, ERR_UNEXPECTED, 1'b1}},
      '{CH_NUL,   1'b0, 1'b0, NO_REC},
      '{8'h31,    1'b0, 1'b0, NO_REC},
      '{CH_DOT,   1'b0, 1'b0, NO_REC},
      '{CH_SEMI,  1'b0, 1'b0, NO_REC},
      '{8'h6B,    1'b0, 1'b0, NO_REC},
      '{8'h45,    1'b0, 1'b0, NO_REC},
      '{8'h79,    1'b0, 1'b0, NO_REC},
      '{CH_LF,    1'b0, 1'b0, NO_REC},
      '{CH_DASH,  1'b0, 1'b0, NO_REC},
      '{CH_DASH,  1'b0, 1'b0, NO_REC},
      '{8'h80,    1'b0, 1'b0, NO_REC},
      '{CH_LF,    1'b0, 1'b0, NO_REC},
      '{CH_QUOTE, 1'b0, 1'b0, NO_REC},
      '{CH_QUOTE, 1'b0, 1'b0, NO_REC},
      '{CH_QUOTE, 1'b0, 1'b0, NO_REC},
      '{8'hFF,    1'b1, 1'b1,
        '{KIND_ERROR, TY_NONE, 8'h00, 16'd3, 16'd1, ERR_UNTERMINATED, 1'b1}}
   };

   string kw_names [KW_COUNT] = '{
      "INSERT", "INTO", "VALUES", "SELECT", "TOP", "FROM", "WHERE", "ORDER", "BY",
      "ASC", "DESC", "LIMIT", "PRIMARY", "KEY", "CREATE", "TABLE", "DROP", "DELETE"
   };

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   lex_state_type lx_mode;
   logic [15:0] lx_line, lx_col, lx_tok_line, lx_tok_col, lx_dot_col;
   logic [55:0] lx_kw;
   logic [3:0]  lx_len;

   rsp_type    step_recs[$];
   rsp_type    pending_records[$];
   logic [7:0] stmt_bytes[$];

   bit idle_on = 1'b1;
   int hold_left = 0;
   int cycle_count = 0;
   int miss_count = 0;
   int live_items = 0;
   int stmt_count = 0;
   int kinds_seen [4] = '{0, 0, 0, 0};

   sql_subset_lexer_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- lexer predictor

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_num_char(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [7:0] upcase(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
   endfunction

   function automatic logic [4:0] mark_type(input logic [7:0] c);
      case (c)
         CH_STAR:   return TY_STAR;
         CH_COMMA:  return TY_COMMA;
         CH_LPAREN: return TY_LPAREN;
         CH_RPAREN: return TY_RPAREN;
         CH_SEMI:   return TY_SEMI;
         CH_EQUAL:  return TY_EQUAL;
         CH_DOT:    return TY_DOT;
         default:   return TY_NONE;
      endcase
   endfunction

   function automatic void add_rec(input logic [1:0] kind, input logic [4:0] ty,
                                   input logic [7:0] txt, input logic [15:0] ln,
                                   input logic [15:0] col, input logic err);
      rsp_type r;
      r = '{kind, ty, txt, ln, col, err, 1'b0};
      step_recs.push_back(r);
   endfunction

   function automatic void bump_pos(input logic [7:0] c);
      if (c == CH_LF) begin
         if (lx_line != POS_TOP) lx_line++;
         lx_col = 16'd1;
      end else if (lx_col != POS_TOP) begin
         lx_col++;
      end
   endfunction

   function automatic void open_token();
      lx_tok_line = lx_line;
      lx_tok_col  = lx_col;
   endfunction

   function automatic void lex_clear();
      lx_mode     = LS_IDLE;
      lx_line     = 16'd1;
      lx_col      = 16'd1;
      lx_tok_line = 16'd1;
      lx_tok_col  = 16'd1;
      lx_dot_col  = 16'd1;
      lx_kw       = '0;
      lx_len      = '0;
   endfunction

   function automatic logic [4:0] word_type();
      logic [55:0] pk;
      string s;
      if (lx_len > 4'd7) return TY_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         s = kw_names[k];
         pk = '0;
         for (int i = 0; i < s.len(); i++) pk = {pk[47:0], s[i]};
         if (s.len() == lx_len && pk == lx_kw) return 5'(k);
      end
      return TY_IDENT;
   endfunction

   // Number, then the held dot as a token of its own
   function automatic void close_dot_number();
      add_rec(KIND_TOKEN, TY_NUMBER, 8'h00, lx_tok_line, lx_tok_col, NO_ERR);
      add_rec(KIND_TEXT, TY_NONE, CH_DOT, lx_line, lx_dot_col, NO_ERR);
      add_rec(KIND_TOKEN, TY_DOT, 8'h00, lx_line, lx_dot_col, NO_ERR);
   endfunction

   function automatic void lex_from_idle(input logic [7:0] c);
      logic [4:0] ty;
      lx_mode = LS_IDLE;
      ty = mark_type(c);
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
         bump_pos(c);
      end else if (c == CH_DASH) begin
         open_token();
         lx_mode = LS_DASH;
         bump_pos(c);
      end else if (is_letter(c) || c == CH_UNDERSCORE) begin
         open_token();
         lx_mode = LS_WORD;
         lx_kw   = {48'd0, upcase(c)};
         lx_len  = 4'd1;
         add_rec(KIND_TEXT, TY_NONE, c, lx_tok_line, lx_tok_col, NO_ERR);
         bump_pos(c);
      end else if (is_num_char(c)) begin
         open_token();
         lx_mode = LS_INT;
         add_rec(KIND_TEXT, TY_NONE, c, lx_tok_line, lx_tok_col, NO_ERR);
         bump_pos(c);
      end else if (c == CH_QUOTE) begin
         open_token();
         lx_mode = LS_STR;
         bump_pos(c);
      end else if (ty != TY_NONE) begin
         add_rec(KIND_TEXT, TY_NONE, c, lx_line, lx_col, NO_ERR);
         add_rec(KIND_TOKEN, ty, 8'h00, lx_line, lx_col, NO_ERR);
         bump_pos(c);
      end else begin
         add_rec(KIND_ERROR, TY_NONE, 8'h00, lx_line, lx_col, ERR_UNEXPECTED);
         lx_mode = LS_SKIP;
      end
   endfunction

   // Work out the records one accepted byte produces into step_recs
   function automatic void lex_byte(input logic [7:0] c, input logic eoi);
      logic with_eof;
      step_recs.delete();
      if (eoi || c == CH_NUL) begin
         with_eof = 1'b1;
         case (lx_mode)
            LS_WORD:
               add_rec(KIND_TOKEN, word_type(), 8'h00, lx_tok_line, lx_tok_col, NO_ERR);
            LS_INT, LS_FRAC:
               add_rec(KIND_TOKEN, TY_NUMBER, 8'h00, lx_tok_line, lx_tok_col, NO_ERR);
            LS_INT_DOT:
               close_dot_number();
            LS_STR_QUOTE:
               add_rec(KIND_TOKEN, TY_STRING, 8'h00, lx_tok_line, lx_tok_col, NO_ERR);
            LS_STR: begin
               add_rec(KIND_ERROR, TY_NONE, 8'h00, lx_tok_line, lx_tok_col, ERR_UNTERMINATED);
               with_eof = 1'b0;
            end
            LS_DASH: begin
               add_rec(KIND_ERROR, TY_NONE, 8'h00, lx_tok_line, lx_tok_col, ERR_UNEXPECTED);
               with_eof = 1'b0;
            end
            LS_SKIP:
               with_eof = 1'b0;
            default: ;
         endcase
         if (with_eof) add_rec(KIND_TOKEN, TY_EOF, 8'h00, lx_line, lx_col, NO_ERR);
         lex_clear();
      end else begin
         case (lx_mode)
            LS_WORD: begin
               if (is_letter(c) || is_num_char(c) || c == CH_UNDERSCORE) begin
                  add_rec(KIND_TEXT, TY_NONE, c, lx_tok_line, lx_tok_col, NO_ERR);
                  if (lx_len < 4'd7) lx_kw = {lx_kw[47:0], upcase(c)};
                  if (lx_len != 4'd15) lx_len++;
                  bump_pos(c);
               end else begin
                  add_rec(KIND_TOKEN, word_type(), 8'h00, lx_tok_line, lx_tok_col, NO_ERR);
                  lex_from_idle(c);
               end
            end
            LS_INT: begin
               if (is_num_char(c)) begin
                  add_rec(KIND_TEXT, TY_NONE, c, lx_tok_line, lx_tok_col, NO_ERR);
                  bump_pos(c);
               end else if (c == CH_DOT) begin
                  lx_dot_col = lx_col;
                  lx_mode = LS_INT_DOT;
                  bump_pos(c);
               end else begin
                  add_rec(KIND_TOKEN, TY_NUMBER, 8'h00, lx_tok_line, lx_tok_col, NO_ERR);
                  lex_from_idle(c);
               end
            end
            LS_INT_DOT: begin
               if (is_num_char(c)) begin
                  add_rec(KIND_TEXT, TY_NONE, CH_DOT, lx_tok_line, lx_tok_col, NO_ERR);
                  add_rec(KIND_TEXT, TY_NONE, c, lx_tok_line, lx_tok_col, NO_ERR);
                  lx_mode = LS_FRAC;
                  bump_pos(c);
               end else begin
                  close_dot_number();
                  lex_from_idle(c);
               end
            end
            LS_FRAC: begin
               if (is_num_char(c)) begin
                  add_rec(KIND_TEXT, TY_NONE, c, lx_tok_line, lx_tok_col, NO_ERR);
                  bump_pos(c);
               end else begin
                  add_rec(KIND_TOKEN, TY_NUMBER, 8'h00, lx_tok_line, lx_tok_col, NO_ERR);
                  lex_from_idle(c);
               end
            end
            LS_STR: begin
               if (c == CH_QUOTE) lx_mode = LS_STR_QUOTE;
               else add_rec(KIND_TEXT, TY_NONE, c, lx_tok_line, lx_tok_col, NO_ERR);
               bump_pos(c);
            end
            LS_STR_QUOTE: begin
               if (c == CH_QUOTE) begin
                  add_rec(KIND_TEXT, TY_NONE, CH_QUOTE, lx_tok_line, lx_tok_col, NO_ERR);
                  lx_mode = LS_STR;
                  bump_pos(c);
               end else begin
                  add_rec(KIND_TOKEN, TY_STRING, 8'h00, lx_tok_line, lx_tok_col, NO_ERR);
                  lex_from_idle(c);
               end
            end
            LS_DASH: begin
               if (c == CH_DASH) begin
                  lx_mode = LS_COMMENT;
                  bump_pos(c);
               end else begin
                  add_rec(KIND_ERROR, TY_NONE, 8'h00, lx_tok_line, lx_tok_col, ERR_UNEXPECTED);
                  lx_mode = LS_SKIP;
               end
            end
            LS_COMMENT: begin
               if (c == CH_LF) lex_from_idle(c);
               else bump_pos(c);
            end
            LS_SKIP: ;
            default: lex_from_idle(c);
         endcase
      end
      if (step_recs.size() != 0) step_recs[$].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- stimulus

   task automatic send_item(input logic [7:0] ch, input logic eoi,
                            input logic typed, input rsp_type want);
      if (idle_on && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{char_byte: ch, end_of_input: eoi};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (lx_mode != LS_SKIP) live_items++;
      lex_byte(ch, eoi);
      if (typed) pending_records.push_back(want);
      else foreach (step_recs[i]) pending_records.push_back(step_recs[i]);
   endtask

   // Hold the sender until every predicted record has come out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_records.size() != 0) @(posedge clock);
   endtask

   task automatic compose_statement();
      int n_tok;
      int pick;
      int len;
      logic [7:0] c;
      string kw;
      stmt_bytes.delete();
      n_tok = $urandom_range(2, 12);
      for (int t = 0; t < n_tok; t++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            // keyword in mixed case
            kw = kw_names[$urandom_range(0, KW_COUNT - 1)];
            for (int i = 0; i < kw.len(); i++)
               stmt_bytes.push_back($urandom_range(0, 1) ? kw[i] : (kw[i] | 8'h20));
         end else if (pick < 42) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 7);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 3))
                  0: c = 8'h41 + 8'($urandom_range(0, 25));
                  1: c = 8'h61 + 8'($urandom_range(0, 25));
                  2: c = (i == 0) ? CH_UNDERSCORE : 8'h30 + 8'($urandom_range(0, 9));
                  default: c = CH_UNDERSCORE;
               endcase
               stmt_bytes.push_back(c);
            end
         end else if (pick < 56) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) stmt_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 1)) begin
               stmt_bytes.push_back(CH_DOT);
               len = $urandom_range(0, 3);
               for (int i = 0; i < len; i++)
                  stmt_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
            end
         end else if (pick < 68) begin
            stmt_bytes.push_back(CH_QUOTE);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
               c = ($urandom_range(0, 5) == 0) ? CH_QUOTE : 8'($urandom_range(1, 255));
               stmt_bytes.push_back(c);
               // double every quote so the string stays open
               if (c == CH_QUOTE) stmt_bytes.push_back(c);
            end
            if ($urandom_range(0, 11) != 0) stmt_bytes.push_back(CH_QUOTE);
         end else if (pick < 84) begin
            case ($urandom_range(0, 6))
               0: c = CH_STAR;
               1: c = CH_COMMA;
               2: c = CH_LPAREN;
               3: c = CH_RPAREN;
               4: c = CH_SEMI;
               5: c = CH_EQUAL;
               default: c = CH_DOT;
            endcase
            stmt_bytes.push_back(c);
         end else if (pick < 90) begin
            stmt_bytes.push_back(CH_DASH);
            stmt_bytes.push_back(CH_DASH);
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++) stmt_bytes.push_back(8'($urandom_range(1, 255)));
            if ($urandom_range(0, 5) != 0) stmt_bytes.push_back(CH_LF);
         end else if (pick < 95) begin
            stmt_bytes.push_back(8'($urandom_range(1, 255)));
         end else begin
            c = 8'($urandom_range(1, 255));
            stmt_bytes.push_back(CH_DASH);
            stmt_bytes.push_back((c == CH_DASH) ? 8'h41 : c);
         end
         if ($urandom_range(0, 9) < 6) begin
            case ($urandom_range(0, 5))
               0: c = CH_TAB;
               1: c = CH_CR;
               2: c = CH_LF;
               default: c = CH_SPACE;
            endcase
            stmt_bytes.push_back(c);
         end
      end
   endtask

   initial begin
      int random_start;
      lex_clear();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (PLAN[i]) send_item(PLAN[i].ch, PLAN[i].eoi, PLAN[i].typed, PLAN[i].want);
      drain();

      random_start = live_items;
      while (live_items - random_start < RANDOM_ITEMS) begin
         if (live_items - random_start > RANDOM_ITEMS * 2 / 3) idle_on = 1'b0;
         if ($urandom_range(0, 9) == 0) drain();
         compose_statement();
         foreach (stmt_bytes[i]) send_item(stmt_bytes[i], 1'b0, 1'b0, NO_REC);
         if ($urandom_range(0, 3) == 0) send_item(CH_NUL, 1'b0, 1'b0, NO_REC);
         else send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_REC);
         stmt_count++;
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Lexed %0d random statements after a directed table of %0d bytes;",
               stmt_count, $size(PLAN));
      $display("checked %0d text, %0d token, %0d error records",
               kinds_seen[KIND_TEXT], kinds_seen[KIND_TOKEN], kinds_seen[KIND_ERROR]);
      if (miss_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------- result side

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 99) < 10) begin
         hold_left <= $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic string rec_text(input rsp_type r);
      return $sformatf("kind %0d type %0d byte %02h at %0d:%0d err %0d last %0d",
                       r.record_kind, r.token_type, r.text_byte, r.at_line,
                       r.at_column, r.error_code, r.last);
   endfunction

   always @(posedge clock) begin : check_records
      rsp_type want;
      string diff;
      if (!reset && rsp_valid && !rsp_stall) begin
         kinds_seen[rsp_data.record_kind]++;
         if (pending_records.size() == 0) begin
            miss_count++;
            if (miss_count <= 10) $display("Unexpected record: %s", rec_text(rsp_data));
         end else begin
            want = pending_records.pop_front();
            diff = "";
            if (rsp_data.record_kind !== want.record_kind) diff = {diff, " kind"};
            if (rsp_data.token_type !== want.token_type) diff = {diff, " type"};
            if (rsp_data.text_byte !== want.text_byte) diff = {diff, " byte"};
            if (rsp_data.at_line !== want.at_line) diff = {diff, " line"};
            if (rsp_data.at_column !== want.at_column) diff = {diff, " column"};
            if (rsp_data.error_code !== want.error_code) diff = {diff, " error"};
            if (rsp_data.last !== want.last) diff = {diff, " last"};
            if (diff != "") begin
               miss_count++;
               if (miss_count <= 10) begin
                  $display("Mismatch in%s at cycle %0d", diff, cycle_count);
                  $display("   expected %s", rec_text(want));
                  $display("   actual   %s", rec_text(rsp_data));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d records outstanding", cycle_count,
                  pending_records.size());
         $display("Some tests failed");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
sv/sslex_pkg.sv
sv/sslex_front.sv
sv/sslex_queue.sv
sv/sslex_back.sv
sv/sql_subset_lexer_core.sv
tb/sv/tb.sv
